FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the console writer RTL.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked only while out of reset.
`define TCW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");
// Property checked at every edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define TCW_ASSERT(lbl, clk, rstn, prop)
`define TCW_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int ROW_W     = 5;
  localparam int COL_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [3:0] FG_RESET     = 4'hF;
  localparam logic [3:0] BG_RESET     = 4'h0;
  localparam logic [7:0] RESET_ATTR   = {BG_RESET, FG_RESET};

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG = 1'b0,
    CFG_BG = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_PUT
  } state_t;

  typedef logic [ROW_W-1:0] row_field_t;
  typedef logic [COL_W-1:0] col_field_t;

  typedef struct packed {
    logic       valid;
    row_field_t cursor_row;
    col_field_t cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } res_t;

endpackage

FILE: rtl/core/tcw_cell_mem.sv
// Cell store: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcw_cell_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] cells_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      cells_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= cells_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/tcw_seq.sv
// Sequencer: cursor, command decode and the scroll/blank sweeps over the cell store.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_seq #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AW      = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          op,
  input  logic [7:0]          character,
  input  logic [4:0]          read_row,
  input  logic [6:0]          read_col,
  input  logic [7:0]          attr,
  output logic                busy,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [15:0]         mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  logic [15:0]         mem_rdata,
  output tcw_pkg::res_t       res
);

  localparam int CELLS         = ROWS * COLUMNS;
  localparam int PW            = $clog2(CELLS + 1);
  localparam int RW            = $clog2(ROWS);
  localparam int CW            = $clog2(COLUMNS + 1);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  tcw_pkg::state_t state_r, state_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [PW-1:0]   ptr_r, ptr_nxt;
  logic            init_r, init_nxt;
  logic            put_pend_r, put_pend_nxt;
  logic            copy_pend_r, copy_pend_nxt;
  logic [7:0]      pend_char_r, pend_char_nxt;
  logic [AW-1:0]   copy_waddr_r, copy_waddr_nxt;

  logic            at_last_row;
  logic            col_full;
  logic            is_newline;
  logic            rd_in_range;
  logic [AW-1:0]   cur_addr;
  logic [AW-1:0]   nl_addr;
  logic [AW-1:0]   rd_addr;
  logic [15:0]     blank_word;

  assign at_last_row = (row_r == RW'(ROWS - 1));
  assign col_full    = (col_r == CW'(COLUMNS));
  assign is_newline  = (character == tcw_pkg::NEWLINE_CODE);
  assign rd_in_range = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);
  assign cur_addr    = AW'(int'(row_r) * COLUMNS + int'(col_r));
  assign nl_addr     = AW'((int'(row_r) + 1) * COLUMNS);
  assign rd_addr     = AW'(int'(read_row) * COLUMNS + int'(read_col));
  // reset sweep always uses the power-on attribute
  assign blank_word  = {tcw_pkg::SPACE_CODE, init_r ? tcw_pkg::RESET_ATTR : attr};
  assign busy        = (state_r != tcw_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_BLANK;
      row_r       <= '0;
      col_r       <= '0;
      ptr_r       <= '0;
      init_r      <= 1'b1;
      put_pend_r  <= 1'b0;
      copy_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      ptr_r       <= ptr_nxt;
      init_r      <= init_nxt;
      put_pend_r  <= put_pend_nxt;
      copy_pend_r <= copy_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_char_r  <= pend_char_nxt;
    copy_waddr_r <= copy_waddr_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    ptr_nxt        = ptr_r;
    init_nxt       = init_r;
    put_pend_nxt   = put_pend_r;
    copy_pend_nxt  = 1'b0;
    pend_char_nxt  = pend_char_r;
    copy_waddr_nxt = copy_waddr_r;
    // trailing write of the scroll copy, in the cycle after its read
    mem_we         = copy_pend_r;
    mem_waddr      = copy_waddr_r;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = ptr_r[AW-1:0];
    res            = '0;

    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          unique case (tcw_pkg::op_t'(op))
            tcw_pkg::OP_PUT: begin
              if (is_newline || col_full) begin
                col_nxt = '0;
                if (!at_last_row) begin
                  row_nxt   = row_r + 1'b1;
                  res.valid = 1'b1;
                  if (!is_newline) begin
                    mem_we    = 1'b1;
                    mem_waddr = nl_addr;
                    mem_wdata = {character, attr};
                    col_nxt   = CW'(1);
                  end
                end else begin
                  state_nxt     = tcw_pkg::ST_SCROLL;
                  ptr_nxt       = PW'(COLUMNS);
                  put_pend_nxt  = !is_newline;
                  pend_char_nxt = character;
                end
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cur_addr;
                mem_wdata = {character, attr};
                col_nxt   = col_r + 1'b1;
                res.valid = 1'b1;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              state_nxt = tcw_pkg::ST_BLANK;
              ptr_nxt   = '0;
            end
            tcw_pkg::OP_READ: begin
              if (rd_in_range) begin
                mem_re    = 1'b1;
                mem_raddr = rd_addr;
                state_nxt = tcw_pkg::ST_READ;
              end else begin
                res.valid = 1'b1;
              end
            end
            tcw_pkg::OP_NOP: begin
              res.valid = 1'b1;
            end
            default: begin
              res.valid = 1'b1;
            end
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        res.valid     = 1'b1;
        res.cell_char = mem_rdata[15:8];
        res.cell_attr = mem_rdata[7:0];
        state_nxt     = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_SCROLL: begin
        // read cell i, write it to i - COLUMNS on the next cycle
        if (ptr_r != PW'(CELLS)) begin
          mem_re         = 1'b1;
          copy_pend_nxt  = 1'b1;
          copy_waddr_nxt = AW'(ptr_r - PW'(COLUMNS));
          ptr_nxt        = ptr_r + 1'b1;
        end else begin
          state_nxt = tcw_pkg::ST_BLANK;
          ptr_nxt   = PW'(LAST_ROW_BASE);
        end
      end
      tcw_pkg::ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        mem_wdata = blank_word;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == PW'(CELLS - 1)) begin
          init_nxt = 1'b0;
          if (put_pend_r) begin
            state_nxt = tcw_pkg::ST_PUT;
          end else begin
            state_nxt = tcw_pkg::ST_IDLE;
            res.valid = !init_r;
          end
        end
      end
      tcw_pkg::ST_PUT: begin
        mem_we       = 1'b1;
        mem_waddr    = AW'(LAST_ROW_BASE);
        mem_wdata    = {pend_char_r, attr};
        col_nxt      = CW'(1);
        put_pend_nxt = 1'b0;
        res.valid    = 1'b1;
        state_nxt    = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase

    res.cursor_row = tcw_pkg::row_field_t'(row_nxt);
    res.cursor_col = tcw_pkg::col_field_t'(col_nxt);
  end

endmodule

FILE: rtl/core/text_console_writer_core.sv
// Text console writer top level: color registers, result register, cell store.
// Depends on tcw_pkg, tcw_seq, tcw_cell_mem and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Ports                                              Beat taken when
// ------    -------------------------------------------------  -------------------
// input     start, busy, in_op, in_character, in_read_row/col  start && !busy
// result    out_strobe, out_cursor_row/col, out_cell_char/attr out_strobe (1 cycle)
// config    cfg_we, cfg_index, cfg_wdata                       cfg_we
//
// Put, newline without scroll, out-of-range read and op 3: result in the cycle
// after the beat, busy stays low. In-range read: through the registered memory
// read port, then the result register. Clear: one cell written per cycle.
// Scroll: one copy per cycle through the single read/write port pair, then the
// bottom row is blanked and a character that follows the new line is written.
// After reset busy is high while the store is blanked.
// Results cannot be stalled; out_strobe is high for one cycle per item.

module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_op,
  input  logic [7:0]                           in_character,
  input  logic [4:0]                           in_read_row,
  input  logic [6:0]                           in_read_col,
  output logic                                 out_strobe,
  output logic [4:0]                           out_cursor_row,
  output logic [6:0]                           out_cursor_col,
  output logic [7:0]                           out_cell_char,
  output logic [7:0]                           out_cell_attr,
  input  logic                                 cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic [3:0]    fg_r;
  logic [3:0]    bg_r;
  logic [7:0]    attr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;
  tcw_pkg::res_t res;
  logic          out_strobe_r;
  tcw_pkg::res_t out_r;

  assign attr = {bg_r, fg_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= tcw_pkg::FG_RESET;
      bg_r <= tcw_pkg::BG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tcw_pkg::CFG_FG) begin
        fg_r <= cfg_wdata;
      end else if (cfg_index == tcw_pkg::CFG_BG) begin
        bg_r <= cfg_wdata;
      end
    end
  end

  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_op),
    .character (in_character),
    .read_row  (in_read_row),
    .read_col  (in_read_col),
    .attr      (attr),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res       (res)
  );

  tcw_cell_mem #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (16)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_r <= res;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_cursor_row = out_r.cursor_row;
  assign out_cursor_col = out_r.cursor_col;
  assign out_cell_char  = out_r.cell_char;
  assign out_cell_attr  = out_r.cell_attr;

  // the store is blanked right after reset
  `TCW_ASSERT_ALWAYS(a_reset_sweep, clk, !rst_n |=> busy)
  // every result lands once the sequencer is back to idle
  `TCW_ASSERT(a_strobe_idle, clk, rst_n, out_strobe |-> !busy)
  // only a read reports cell contents
  `TCW_ASSERT(a_cell_zero, clk, rst_n,
    (start && !busy && in_op != tcw_pkg::OP_READ) |=>
      (!out_strobe || (out_cell_char == 8'd0 && out_cell_attr == 8'd0)))

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for text_console_writer_core: directed table, then random text traffic.
// Depends on tcw_pkg and the core RTL; keeps its own copy of the screen, cursor and colors.
`timescale 1ns / 1ps

module tb_top;

  localparam int COLS         = 80;
  localparam int ROWS_N       = 25;
  localparam int CELLS        = COLS * ROWS_N;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 260;
  localparam int LIMIT_CYCLES = 20_000_000;

  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] chr;
    logic [7:0] attr;
  } cell_report_t;

  typedef struct {
    tcw_pkg::op_t op;
    logic [7:0]   chr;
    logic [4:0]   rr;
    logic [6:0]   rc;
    int           reps;
    bit           typed;
    cell_report_t rep;
  } dir_row_t;

  localparam cell_report_t NO_REP = '0;
  localparam int DIR_ROWS = 26;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_op;
  logic [7:0] in_character;
  logic [4:0] in_read_row;
  logic [6:0] in_read_col;
  logic       out_strobe;
  logic [4:0] out_cursor_row;
  logic [6:0] out_cursor_col;
  logic [7:0] out_cell_char;
  logic [7:0] out_cell_attr;
  logic       cfg_we;
  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // screen model
  logic [7:0] screen_char [CELLS];
  logic [7:0] screen_attr [CELLS];
  int         cur_row;
  int         cur_col;
  logic [3:0] fg_color;
  logic [3:0] bg_color;

  cell_report_t pending_reports [$];
  bit           drv_typed;
  cell_report_t drv_expect;
  bit           gaps_on;
  dir_row_t     dir_tab [DIR_ROWS];

  int errors;
  int checked;
  int items_sent;
  int scrolls;
  int clears;
  int wd_cycles;

  text_console_writer_core #(
    .COLUMNS(COLS),
    .ROWS   (ROWS_N)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_character  (in_character),
    .in_read_row   (in_read_row),
    .in_read_col   (in_read_col),
    .out_strobe    (out_strobe),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void blank_row(int r);
    for (int c = 0; c < COLS; c++) begin
      screen_char[r * COLS + c] = tcw_pkg::SPACE_CODE;
      screen_attr[r * COLS + c] = {bg_color, fg_color};
    end
  endfunction

  function automatic void next_line();
    cur_col = 0;
    if (cur_row < ROWS_N - 1) begin
      cur_row++;
    end else begin
      for (int i = COLS; i < CELLS; i++) begin
        screen_char[i - COLS] = screen_char[i];
        screen_attr[i - COLS] = screen_attr[i];
      end
      blank_row(ROWS_N - 1);
      scrolls++;
    end
  endfunction

  function automatic cell_report_t console_apply(tcw_pkg::op_t op, logic [7:0] chr,
                                                 logic [4:0] rr, logic [6:0] rc);
    cell_report_t rep;
    rep = '0;
    case (op)
      tcw_pkg::OP_PUT: begin
        if (chr == tcw_pkg::NEWLINE_CODE) begin
          next_line();
        end else begin
          // full line: the next non-newline char wraps first
          if (cur_col >= COLS) next_line();
          screen_char[cur_row * COLS + cur_col] = chr;
          screen_attr[cur_row * COLS + cur_col] = {bg_color, fg_color};
          cur_col++;
        end
      end
      tcw_pkg::OP_CLEAR: begin
        for (int r = 0; r < ROWS_N; r++) blank_row(r);
        clears++;
      end
      tcw_pkg::OP_READ: begin
        if (int'(rr) < ROWS_N && int'(rc) < COLS) begin
          rep.chr  = screen_char[int'(rr) * COLS + int'(rc)];
          rep.attr = screen_attr[int'(rr) * COLS + int'(rc)];
        end
      end
      default: ;
    endcase
    rep.row = 5'(cur_row);
    rep.col = 7'(cur_col);
    return rep;
  endfunction

  function automatic void report_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // result check first, then config, then the beat taken at this edge
  always @(posedge clk) begin
    cell_report_t want;
    cell_report_t pred;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_reports.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: row %0d col %0d char %0d attr %0d",
                   $time, out_cursor_row, out_cursor_col, out_cell_char, out_cell_attr);
        end else begin
          want = pending_reports.pop_front();
          checked++;
          report_field("cursor_row", want.row, out_cursor_row);
          report_field("cursor_col", want.col, out_cursor_col);
          report_field("cell_char", want.chr, out_cell_char);
          report_field("cell_attr", want.attr, out_cell_attr);
        end
      end
      if (cfg_we) begin
        case (tcw_pkg::cfg_idx_t'(cfg_index))
          tcw_pkg::CFG_FG: fg_color = cfg_wdata;
          tcw_pkg::CFG_BG: bg_color = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        pred = console_apply(tcw_pkg::op_t'(in_op), in_character, in_read_row, in_read_col);
        pending_reports.push_back(drv_typed ? drv_expect : pred);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_item(tcw_pkg::op_t op, logic [7:0] chr, logic [4:0] rr,
                           logic [6:0] rc, bit typed, cell_report_t rep);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    start        = 1'b1;
    in_op        = op;
    in_character = chr;
    in_read_row  = rr;
    in_read_col  = rc;
    drv_typed    = typed;
    drv_expect   = rep;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // mostly reads around the cursor, some anywhere in the field range
  task automatic pick_read();
    logic [4:0] rr;
    logic [6:0] rc;
    if ($urandom_range(0, 3) != 0) begin
      rr = (cur_row > 0 && $urandom_range(0, 1) == 1) ? 5'(cur_row - 1) : 5'(cur_row);
      rc = 7'($urandom_range(0, COLS - 1));
    end else begin
      rr = 5'($urandom_range(0, 31));
      rc = 7'($urandom_range(0, 127));
    end
    send_item(tcw_pkg::OP_READ, 8'($urandom_range(0, 255)), rr, rc, 1'b0, NO_REP);
  endtask

  task automatic settle();
    start = 1'b0;
    while (pending_reports.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    for (wd_cycles = 0; wd_cycles < LIMIT_CYCLES; wd_cycles++) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int         len;
    int         pick;
    int         phase_base;
    logic [3:0] fg_set;
    logic [3:0] bg_set;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_op        = tcw_pkg::OP_PUT;
    in_character = 8'd0;
    in_read_row  = 5'd0;
    in_read_col  = 7'd0;
    cfg_we       = 1'b0;
    cfg_index    = tcw_pkg::CFG_FG;
    cfg_wdata    = 4'd0;
    drv_typed    = 1'b0;
    drv_expect   = NO_REP;
    gaps_on      = 1'b1;
    errors       = 0;
    checked      = 0;
    items_sent   = 0;
    scrolls      = 0;
    clears       = 0;

    fg_color = tcw_pkg::FG_RESET;
    bg_color = tcw_pkg::BG_RESET;
    for (int r = 0; r < ROWS_N; r++) blank_row(r);
    cur_row = 0;
    cur_col = 0;

    dir_tab = '{
      '{tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd0, 1, 1'b1, '{5'd0, 7'd0, 8'h20, 8'h0F}},
      '{tcw_pkg::OP_READ, 8'h00, 5'd24, 7'd79, 1, 1'b1, '{5'd0, 7'd0, 8'h20, 8'h0F}},
      '{tcw_pkg::OP_READ, 8'h00, 5'd25, 7'd0, 1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
      '{tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd80, 1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
      '{tcw_pkg::OP_READ, 8'hFF, 5'd31, 7'd127, 1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
      '{tcw_pkg::OP_NOP, 8'hFF, 5'd31, 7'd127, 1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
      '{tcw_pkg::OP_PUT, 8'h00, 5'd0, 7'd0, 1, 1'b1, '{5'd0, 7'd1, 8'h00, 8'h00}},
      '{tcw_pkg::OP_PUT, 8'hFF, 5'd31, 7'd127, 1, 1'b1, '{5'd0, 7'd2, 8'h00, 8'h00}},
      '{tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd0, 1, 1'b1, '{5'd0, 7'd2, 8'h00, 8'h0F}},
      '{tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd1, 1, 1'b1, '{5'd0, 7'd2, 8'hFF, 8'h0F}},
      '{tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 5'd0, 7'd0, 1, 1'b1, '{5'd1, 7'd0, 8'h00, 8'h00}},
      '{tcw_pkg::OP_PUT, 8'h41, 5'd0, 7'd0, 1, 1'b1, '{5'd1, 7'd1, 8'h00, 8'h00}},
      '{tcw_pkg::OP_CLEAR, 8'h00, 5'd0, 7'd0, 1, 1'b1, '{5'd1, 7'd1, 8'h00, 8'h00}},
      '{tcw_pkg::OP_READ, 8'h00, 5'd1, 7'd0, 1, 1'b1, '{5'd1, 7'd1, 8'h20, 8'h0F}},
      // fill row 1 to the last column, then wrap
      '{tcw_pkg::OP_PUT, 8'h42, 5'd0, 7'd0, 79, 1'b0, NO_REP},
      '{tcw_pkg::OP_PUT, 8'h43, 5'd0, 7'd0, 1, 1'b1, '{5'd2, 7'd1, 8'h00, 8'h00}},
      '{tcw_pkg::OP_READ, 8'h00, 5'd1, 7'd79, 1, 1'b1, '{5'd2, 7'd1, 8'h42, 8'h0F}},
      '{tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 5'd0, 7'd0, 22, 1'b0, NO_REP},
      '{tcw_pkg::OP_PUT, 8'h44, 5'd0, 7'd0, 1, 1'b1, '{5'd24, 7'd1, 8'h00, 8'h00}},
      // newline on the bottom row scrolls
      '{tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 5'd0, 7'd0, 1, 1'b1, '{5'd24, 7'd0, 8'h00, 8'h00}},
      '{tcw_pkg::OP_READ, 8'h00, 5'd23, 7'd0, 1, 1'b1, '{5'd24, 7'd0, 8'h44, 8'h0F}},
      '{tcw_pkg::OP_READ, 8'h00, 5'd1, 7'd0, 1, 1'b1, '{5'd24, 7'd0, 8'h43, 8'h0F}},
      '{tcw_pkg::OP_READ, 8'h00, 5'd24, 7'd0, 1, 1'b1, '{5'd24, 7'd0, 8'h20, 8'h0F}},
      // full bottom row, then a wrap that scrolls
      '{tcw_pkg::OP_PUT, 8'h45, 5'd0, 7'd0, 80, 1'b0, NO_REP},
      '{tcw_pkg::OP_PUT, 8'h46, 5'd0, 7'd0, 1, 1'b1, '{5'd24, 7'd1, 8'h00, 8'h00}},
      '{tcw_pkg::OP_READ, 8'h00, 5'd23, 7'd79, 1, 1'b0, NO_REP}
    };

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[k]) begin
      for (int n = 0; n < dir_tab[k].reps; n++) begin
        send_item(dir_tab[k].op, dir_tab[k].chr, dir_tab[k].rr, dir_tab[k].rc,
                  dir_tab[k].typed, dir_tab[k].rep);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // every phase starts drained, so the color writes land while idle
      settle();
      case (ph)
        0: begin fg_set = 4'h0; bg_set = 4'hF; end
        1: begin fg_set = 4'hF; bg_set = 4'hF; end
        2: begin fg_set = 4'h0; bg_set = 4'h0; end
        PHASES - 1: begin fg_set = tcw_pkg::FG_RESET; bg_set = tcw_pkg::BG_RESET; end
        default: begin
          fg_set = 4'($urandom_range(0, 15));
          bg_set = 4'($urandom_range(0, 15));
        end
      endcase
      cfg_we    = 1'b1;
      cfg_index = tcw_pkg::CFG_FG;
      cfg_wdata = fg_set;
      @(negedge clk);
      cfg_index = tcw_pkg::CFG_BG;
      cfg_wdata = bg_set;
      @(negedge clk);
      cfg_we = 1'b0;

      gaps_on    = (ph != PHASES - 1);
      phase_base = items_sent;
      while (items_sent - phase_base < PHASE_ITEMS) begin
        if (ph != PHASES - 1 && $urandom_range(0, 7) == 0) gaps_on = $urandom_range(0, 2) != 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // a line of text: short, exactly full, or long enough to wrap
          case ($urandom_range(0, 9))
            0: len = COLS;
            1: len = $urandom_range(COLS + 1, COLS + 10);
            default: len = $urandom_range(0, 40);
          endcase
          for (int i = 0; i < len; i++) begin
            send_item(tcw_pkg::OP_PUT, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                      7'($urandom_range(0, 127)), 1'b0, NO_REP);
            if ($urandom_range(0, 4) == 0) pick_read();
          end
          if ($urandom_range(0, 9) < 7) begin
            send_item(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 5'($urandom_range(0, 31)),
                      7'($urandom_range(0, 127)), 1'b0, NO_REP);
          end
        end else if (pick < 82) begin
          repeat ($urandom_range(1, 4)) pick_read();
        end else if (pick < 87) begin
          send_item(tcw_pkg::OP_NOP, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                    7'($urandom_range(0, 127)), 1'b0, NO_REP);
        end else if (pick < 93) begin
          send_item(tcw_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                    7'($urandom_range(0, 127)), 1'b0, NO_REP);
          pick_read();
        end else begin
          repeat ($urandom_range(1, 3)) begin
            send_item(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 5'($urandom_range(0, 31)),
                      7'($urandom_range(0, 127)), 1'b0, NO_REP);
          end
        end
      end
    end

    settle();
    $display("%0d beats over %0d color settings, %0d results checked",
             items_sent, PHASES + 1, checked);
    $display("%0d scrolls and %0d clears exercised, %0d mismatches", scrolls, clears, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_cell_mem.sv
rtl/core/tcw_seq.sv
rtl/core/text_console_writer_core.sv
tb/tb_top.sv
